// ----- design/pglide_pkg.sv -----
// Shared types, constants and the microcode program of the portamento glide block.
`default_nettype none

package pglide_pkg;

	// Field and register widths fixed by the interface.
	localparam int VALUE_BITS_DEF = 16;
	localparam int IN_VAL_BITS    = 16;
	localparam int TICK_BITS      = 8;
	localparam int LEN_BITS       = 16;
	localparam int CFG_IDX_BITS   = 8;
	localparam int CFG_DATA_BITS  = 16;
	localparam int IN_TDATA_BITS  = 24;

	localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_BITS-1:0] REG_GLIDE_SPEED = 8'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_PROP_MODE   = 8'd1;

	// Request kinds carried in tuser.
	localparam logic REQ_SET_TARGET = 1'b0;
	localparam logic REQ_ADVANCE    = 1'b1;

	// Datapath micro-operations.
	typedef enum logic [2:0] {
		OP_NOP,
		OP_SET_CHECK,
		OP_LEN_CHECK,
		OP_MUL_STEP,
		OP_DIV_STEP,
		OP_WRITE,
		OP_ADV_CHECK,
		OP_ADV_CMP
	} uop_t;

	// Microprogram addresses.
	typedef enum logic [2:0] {
		UPC_SET,
		UPC_LEN,
		UPC_MUL,
		UPC_DIV,
		UPC_WB,
		UPC_ADV,
		UPC_CMP,
		UPC_DONE
	} upc_t;

	// One control word: operation, conditional jump on the datapath flag,
	// fall-through address and end-of-program mark.
	typedef struct packed {
		uop_t op;
		logic use_flag;
		upc_t jmp;
		upc_t nxt;
		logic last;
	} ctrl_word_t;

	// Status returned by the datapath to the sequencer.
	typedef struct packed {
		logic flag;
	} dp_status_t;

	// Read-only microprogram.
	function automatic ctrl_word_t rom_word(upc_t pc);
		ctrl_word_t w;
		w = '{op: OP_NOP, use_flag: 1'b0, jmp: UPC_DONE, nxt: UPC_DONE, last: 1'b0};
		case (pc)
			UPC_SET: w = '{op: OP_SET_CHECK, use_flag: 1'b1, jmp: UPC_DONE, nxt: UPC_LEN,
				last: 1'b0};
			UPC_LEN: w = '{op: OP_LEN_CHECK, use_flag: 1'b1, jmp: UPC_DONE, nxt: UPC_MUL,
				last: 1'b0};
			UPC_MUL: w = '{op: OP_MUL_STEP, use_flag: 1'b1, jmp: UPC_MUL, nxt: UPC_DIV,
				last: 1'b0};
			UPC_DIV: w = '{op: OP_DIV_STEP, use_flag: 1'b1, jmp: UPC_DIV, nxt: UPC_WB,
				last: 1'b0};
			UPC_WB: w = '{op: OP_WRITE, use_flag: 1'b0, jmp: UPC_DONE, nxt: UPC_DONE,
				last: 1'b0};
			UPC_ADV: w = '{op: OP_ADV_CHECK, use_flag: 1'b1, jmp: UPC_DONE, nxt: UPC_CMP,
				last: 1'b0};
			UPC_CMP: w = '{op: OP_ADV_CMP, use_flag: 1'b1, jmp: UPC_DONE, nxt: UPC_MUL,
				last: 1'b0};
			UPC_DONE: w = '{op: OP_NOP, use_flag: 1'b0, jmp: UPC_DONE, nxt: UPC_DONE,
				last: 1'b1};
			default: w = '{op: OP_NOP, use_flag: 1'b0, jmp: UPC_DONE, nxt: UPC_DONE,
				last: 1'b1};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ----- design/pglide_seq.sv -----
// Microcode sequencer: step counter, program table and conditional jumps.
`default_nettype none

module pglide_seq
	import pglide_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	input  upc_t        entry,
	input  wire         hold,
	input  dp_status_t  status,
	output uop_t        op,
	output logic        busy,
	output logic        done
);

	upc_t       pc_q;
	upc_t       pc_next;
	logic       busy_q;
	logic       busy_next;
	ctrl_word_t word;

	assign word = rom_word(pc_q);

	// Next step: start at an entry, jump on the flag, fall through, or go idle at the end unless held.
	always_comb begin
		pc_next   = pc_q;
		busy_next = busy_q;
		if (start) begin
			pc_next   = entry;
			busy_next = 1'b1;
		end else if (busy_q) begin
			if (word.last) begin
				if (!hold) begin
					busy_next = 1'b0;
				end
			end else if (word.use_flag && status.flag) begin
				pc_next = word.jmp;
			end else begin
				pc_next = word.nxt;
			end
		end
	end

	// Control outputs for the current step.
	always_comb begin
		op   = busy_q ? word.op : OP_NOP;
		busy = busy_q;
		done = busy_q && word.last && !hold;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= UPC_DONE;
			busy_q <= 1'b0;
		end else begin
			pc_q   <= pc_next;
			busy_q <= busy_next;
		end
	end

endmodule

`default_nettype wire

// ----- design/pglide_dp.sv -----
// Glide datapath: state registers and a shared shift-add multiplier and restoring divider.
`default_nettype none

module pglide_dp
	import pglide_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  uop_t                  op,
	input  wire  [VALUE_BITS-1:0] new_value,
	input  wire  [TICK_BITS-1:0]  ticks,
	input  wire  [LEN_BITS-1:0]   glide_speed,
	input  wire                   proportional_mode,
	output dp_status_t            status,
	output logic [VALUE_BITS-1:0] current_value,
	output logic                  gliding
);

	localparam int DW = (VALUE_BITS > LEN_BITS) ? VALUE_BITS : LEN_BITS;
	localparam int PW = VALUE_BITS + LEN_BITS;
	localparam int CW = $clog2(PW + 1);

	logic [VALUE_BITS-1:0] target_q;
	logic [VALUE_BITS-1:0] output_q;
	logic [VALUE_BITS-1:0] start_q;
	logic [LEN_BITS-1:0]   elapsed_q;
	logic [LEN_BITS-1:0]   length_q;

	logic [VALUE_BITS-1:0] mcand_q;
	logic [PW-1:0]         acc_q;
	logic [DW-1:0]         divisor_q;
	logic [DW-1:0]         rem_q;
	logic [CW-1:0]         cnt_q;
	logic                  neg_q;
	logic                  len_job_q;

	logic [VALUE_BITS-1:0] dist_abs;
	logic [VALUE_BITS-1:0] div_sel;
	logic [VALUE_BITS-1:0] span;
	logic                  span_neg;
	logic [LEN_BITS:0]     e_sum;
	logic [LEN_BITS-1:0]   e_sat;
	logic [VALUE_BITS:0]   mul_sum;
	logic [DW:0]           div_try;
	logic                  div_ge;
	logic [DW:0]           div_diff;
	logic [LEN_BITS-1:0]   len_sat;
	logic [VALUE_BITS-1:0] adv_value;
	logic                  cnt_more;

	// Operand selection and one step of each iterative unit.
	always_comb begin
		dist_abs  = (target_q > output_q) ? (target_q - output_q) : (output_q - target_q);
		div_sel   = (target_q > start_q) ? output_q : target_q;
		span_neg  = (target_q < start_q);
		span      = span_neg ? (start_q - target_q) : (target_q - start_q);
		e_sum     = {1'b0, elapsed_q} + {{(LEN_BITS + 1 - TICK_BITS){1'b0}}, ticks};
		e_sat     = e_sum[LEN_BITS] ? LEN_MAX : e_sum[LEN_BITS-1:0];
		mul_sum   = {1'b0, acc_q[PW-1:LEN_BITS]}
			+ (acc_q[0] ? {1'b0, mcand_q} : {(VALUE_BITS + 1){1'b0}});
		div_try   = {rem_q, acc_q[PW-1]};
		div_ge    = (div_try >= {1'b0, divisor_q});
		div_diff  = div_try - {1'b0, divisor_q};
		len_sat   = (|acc_q[PW-1:LEN_BITS]) ? LEN_MAX : acc_q[LEN_BITS-1:0];
		adv_value = neg_q ? (start_q - acc_q[VALUE_BITS-1:0])
			: (start_q + acc_q[VALUE_BITS-1:0]);
		cnt_more  = (cnt_q != CW'(1));
	end

	// Jump flag for the sequencer.
	always_comb begin
		case (op)
			OP_SET_CHECK: status.flag = (new_value == target_q) || (new_value == output_q);
			OP_LEN_CHECK: status.flag = (glide_speed == '0) || !proportional_mode
				|| (div_sel == '0);
			OP_MUL_STEP:  status.flag = cnt_more;
			OP_DIV_STEP:  status.flag = cnt_more;
			OP_ADV_CHECK: status.flag = (output_q == target_q) || (length_q == '0);
			OP_ADV_CMP:   status.flag = (elapsed_q > length_q);
			default:      status.flag = 1'b0;
		endcase
	end

	// Glide state, cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= '0;
			output_q  <= '0;
			start_q   <= '0;
			elapsed_q <= '0;
			length_q  <= '0;
		end else begin
			case (op)
				OP_SET_CHECK: begin
					if (!status.flag) begin
						target_q  <= new_value;
						start_q   <= output_q;
						elapsed_q <= '0;
					end
				end
				OP_LEN_CHECK: begin
					if (glide_speed == '0) begin
						length_q <= '0;
					end else if (!proportional_mode) begin
						length_q <= glide_speed;
					end else if (div_sel == '0) begin
						length_q <= '0;
					end
				end
				OP_WRITE: begin
					if (len_job_q) begin
						length_q <= len_sat;
					end else begin
						output_q <= adv_value;
					end
				end
				OP_ADV_CHECK: begin
					if (output_q == target_q) begin
						start_q <= output_q;
					end else if (length_q == '0) begin
						output_q <= target_q;
					end else begin
						elapsed_q <= e_sat;
					end
				end
				OP_ADV_CMP: begin
					if (status.flag) begin
						output_q <= target_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Multiply-divide working registers.
	always_ff @(posedge clk) begin
		case (op)
			OP_LEN_CHECK: begin
				mcand_q   <= dist_abs;
				acc_q     <= {{VALUE_BITS{1'b0}}, glide_speed};
				divisor_q <= DW'(div_sel);
				cnt_q     <= CW'(LEN_BITS);
				len_job_q <= 1'b1;
			end
			OP_ADV_CMP: begin
				mcand_q   <= span;
				acc_q     <= {{VALUE_BITS{1'b0}}, elapsed_q};
				divisor_q <= DW'(length_q);
				neg_q     <= span_neg;
				cnt_q     <= CW'(LEN_BITS);
				len_job_q <= 1'b0;
			end
			OP_MUL_STEP: begin
				acc_q <= {mul_sum, acc_q[LEN_BITS-1:1]};
				if (cnt_more) begin
					cnt_q <= cnt_q - CW'(1);
				end else begin
					cnt_q <= CW'(PW);
					rem_q <= '0;
				end
			end
			OP_DIV_STEP: begin
				rem_q <= div_ge ? div_diff[DW-1:0] : div_try[DW-1:0];
				acc_q <= {acc_q[PW-2:0], div_ge};
				cnt_q <= cnt_q - CW'(1);
			end
			default: begin
			end
		endcase
	end

	// Result fields.
	always_comb begin
		current_value = output_q;
		gliding       = (output_q != target_q);
	end

endmodule

`default_nettype wire

// ----- design/portamento_glide.sv -----
// Portamento glide top level: stream channels, configuration port and output register.
// Input channel s_*: tuser is req_type (set target or advance), tdata carries
// target_value in bits 15:0 and ticks_elapsed in bits 23:16. Every accepted item
// returns one result on m_*: tdata is current_value, tuser is the gliding flag.
// The cfg_* channel writes glide_speed (index 0) or proportional_mode (index 1);
// such a write recomputes the glide length, other indexes are ignored.
// One item is processed at a time by a microcoded sequencer. An ignored target,
// a settled advance or an advance with a zero length ends after its first check
// step; a new target with a zero length or an advance past the length ends after
// its second check step. An item that needs the multiply and divide runs its
// checks, the 16-step shift-add multiplier, the bit-serial restoring divider and
// a write-back step. The next item can be accepted at the earliest in the cycle
// after the result is stored.
// A configuration write keeps the sequencer busy for the length check alone, or
// also for the multiply, divide and write-back when the length needs the divide.
// s_tready and cfg_ready are high only while the sequencer is idle; s_tready
// also stays low while a configuration write is offered. The result waits in an
// output register; if the receiver stalls, the next item may still be accepted
// and runs until its result can be stored.
// Reset clears all glide state and configuration to zero and empties the output.
`default_nettype none

module portamento_glide
	import pglide_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [IN_TDATA_BITS-1:0]     s_tdata,   // target_value[15:0], ticks_elapsed[23:16]
	input  wire                          s_tuser,   // req_type
	output logic                         m_tvalid,
	input  wire                          m_tready,
	output logic [((VALUE_BITS+7)/8)*8-1:0] m_tdata, // current_value
	output logic                         m_tuser,   // gliding
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [CFG_IDX_BITS-1:0]      cfg_index,
	input  wire  [CFG_DATA_BITS-1:0]     cfg_data
);

	localparam int OUT_BITS = ((VALUE_BITS + 7) / 8) * 8;

	logic [LEN_BITS-1:0]   glide_speed_q;
	logic                  prop_mode_q;
	logic [VALUE_BITS-1:0] new_value_q;
	logic [TICK_BITS-1:0]  ticks_q;
	logic                  item_job_q;
	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] out_value_q;
	logic                  out_gliding_q;

	logic                  busy;
	logic                  done;
	logic                  hold;
	logic                  in_fire;
	logic                  cfg_fire;
	logic                  cfg_known;
	logic                  start;
	upc_t                  entry;
	uop_t                  op;
	dp_status_t            status;
	logic [VALUE_BITS-1:0] cur_value;
	logic                  cur_gliding;

	// Handshakes and program entry selection.
	always_comb begin
		cfg_ready = !busy;
		s_tready  = !busy && !cfg_valid;
		in_fire   = s_tvalid && s_tready;
		cfg_fire  = cfg_valid && cfg_ready;
		cfg_known = (cfg_index == REG_GLIDE_SPEED) || (cfg_index == REG_PROP_MODE);
		start     = in_fire || (cfg_fire && cfg_known);
		if (cfg_fire) begin
			entry = UPC_LEN;
		end else if (s_tuser == REQ_ADVANCE) begin
			entry = UPC_ADV;
		end else begin
			entry = UPC_SET;
		end
		hold      = item_job_q && out_valid_q && !m_tready;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glide_speed_q <= '0;
			prop_mode_q   <= 1'b0;
		end else if (cfg_fire) begin
			case (cfg_index)
				REG_GLIDE_SPEED: glide_speed_q <= cfg_data[LEN_BITS-1:0];
				REG_PROP_MODE:   prop_mode_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// Job kind: an item returns a result, a configuration recompute does not.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_job_q <= 1'b0;
		end else if (start) begin
			item_job_q <= in_fire;
		end
	end

	// Input fields held for the running item.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			new_value_q <= VALUE_BITS'(s_tdata[IN_VAL_BITS-1:0]);
			ticks_q     <= s_tdata[IN_VAL_BITS+TICK_BITS-1:IN_VAL_BITS];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done && item_job_q) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done && item_job_q) begin
			out_value_q   <= cur_value;
			out_gliding_q <= cur_gliding;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_BITS'(out_value_q);
	assign m_tuser  = out_gliding_q;

	pglide_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.entry  (entry),
		.hold   (hold),
		.status (status),
		.op     (op),
		.busy   (busy),
		.done   (done)
	);

	pglide_dp #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.op                (op),
		.new_value         (new_value_q),
		.ticks             (ticks_q),
		.glide_speed       (glide_speed_q),
		.proportional_mode (prop_mode_q),
		.status            (status),
		.current_value     (cur_value),
		.gliding           (cur_gliding)
	);

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking testbench for the portamento glide block with a scoreboard and stream drivers.

module tb_top;
	import pglide_pkg::*;

	localparam int HOLD_CYCLES = 200;
	localparam int SETTLE_CYCLES = 60;
	localparam int REPORT_LIMIT = 10;

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [IN_TDATA_BITS-1:0] s_tdata;   // target_value[15:0], ticks_elapsed[23:16]
	logic                     s_tuser;   // req_type
	logic                     m_tvalid;
	logic                     m_tready;
	logic [15:0]              m_tdata;   // current_value
	logic                     m_tuser;   // gliding
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	// Shared controls of the idling behavior.
	bit calm;
	bit hold_request;

	typedef struct packed {
		logic [15:0] value;
		logic        gliding;
	} glide_result_t;

	// Tracks the glide state and the results that accepted items must produce.
	class glide_scoreboard;
		logic [15:0] speed;
		logic        prop;
		logic [15:0] tgt;
		logic [15:0] cur;
		logic [15:0] start;
		logic [15:0] elapsed;
		logic [15:0] len;
		glide_result_t pending_results[$];
		int mismatch_count;

		function void clear_state();
			speed = '0;
			prop = 1'b0;
			tgt = '0;
			cur = '0;
			start = '0;
			elapsed = '0;
			len = '0;
			pending_results.delete();
			mismatch_count = 0;
		endfunction

		// Glide length from the speed, the mode and the glide endpoints.
		function void update_length();
			longint unsigned dist_abs;
			longint unsigned dvsr;
			longint unsigned prod;
			if (speed == 0) begin
				len = '0;
			end else if (!prop) begin
				len = speed;
			end else begin
				dist_abs = (tgt > cur) ? longint'(tgt) - longint'(cur)
					: longint'(cur) - longint'(tgt);
				dvsr = (tgt > start) ? longint'(cur) : longint'(tgt);
				if (dvsr == 0) begin
					len = '0;
				end else begin
					prod = dist_abs * longint'(speed) / dvsr;
					len = (prod > longint'(LEN_MAX)) ? LEN_MAX : prod[15:0];
				end
			end
		endfunction

		function void write_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
			if (idx == REG_GLIDE_SPEED) begin
				speed = data;
				update_length();
			end else if (idx == REG_PROP_MODE) begin
				prop = data[0];
				update_length();
			end
		endfunction

		// Applies one accepted item and queues the result it causes.
		function void note_input(logic req, logic [15:0] tv, logic [7:0] ticks);
			int unsigned sum;
			longint diff;
			longint step;
			longint pos;
			glide_result_t res;
			if (req == REQ_SET_TARGET) begin
				if (tv != tgt && tv != cur) begin
					tgt = tv;
					start = cur;
					elapsed = '0;
					update_length();
				end
			end else if (cur != tgt) begin
				if (len == 0) begin
					cur = tgt;
				end else begin
					sum = int'(elapsed) + int'(ticks);
					elapsed = (sum > 65535) ? LEN_MAX : sum[15:0];
					if (elapsed > len) begin
						cur = tgt;
					end else begin
						diff = longint'(tgt) - longint'(start);
						step = longint'(elapsed) * diff / longint'(len);
						pos = longint'(start) + step;
						cur = pos[15:0];
					end
				end
			end else if (start != cur) begin
				start = cur;
			end
			res.value = cur;
			res.gliding = (cur != tgt);
			pending_results.push_back(res);
		endfunction

		function void check_result(logic [15:0] value, logic gliding);
			glide_result_t exp_res;
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected result: value %0d gliding %0b", value, gliding);
			end else begin
				exp_res = pending_results.pop_front();
				if (value !== exp_res.value || gliding !== exp_res.gliding) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("mismatch: expected value %0d gliding %0b, got value %0d gliding %0b",
							exp_res.value, exp_res.gliding, value, gliding);
				end
			end
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	glide_scoreboard sb = new();

	portamento_glide dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Clock generation.
	always #5 clk = ~clk;

	// Run limit.
	initial begin
		#20000000;
		$display("TEST FAILED");
		$finish;
	end

	// Receiver readiness: random short stalls, plus one long hold-off on request.
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready = 1'b1;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else if (hold_request) begin
				hold_request = 1'b0;
				stall_left = HOLD_CYCLES - 1;
				m_tready = 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 2);
				m_tready = 1'b0;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// Result monitor: every output transfer is checked against the oldest expectation.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_result(m_tdata, m_tuser);
		end
	end

	// Offers one item, after an optional idle burst, and waits for its transfer.
	task automatic send_item(input logic req, input logic [15:0] tv, input logic [7:0] ticks);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 3);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = req;
		s_tdata = {ticks, tv};
		do @(posedge clk); while (!s_tready);
		sb.note_input(req, tv, ticks);
	endtask

	// Stops offering items and waits until every expected result has arrived.
	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
	endtask

	// Writes one register while the block is idle.
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_DATA_BITS-1:0] data);
		drain();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_register(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Sets speed and mode for the next phase; sometimes also hits an unused index.
	task automatic setup_phase(input logic [15:0] speed, input logic mode);
		logic [15:0] mode_word;
		mode_word = 16'($urandom_range(0, 65535));
		mode_word[0] = mode;
		if ($urandom_range(0, 1) == 0)
			write_reg(CFG_IDX_BITS'($urandom_range(2, 255)),
				CFG_DATA_BITS'($urandom_range(0, 65535)));
		write_reg(REG_GLIDE_SPEED, speed);
		write_reg(REG_PROP_MODE, mode_word);
	endtask

	// Random mix of set-target and advance items with biased values.
	task automatic random_phase(input int count, input int set_pct, input bit long_glide,
		input int hold_at);
		int i;
		int pick;
		logic req;
		logic [15:0] tv;
		logic [7:0] ticks;
		for (i = 0; i < count; i++) begin
			if (i == hold_at)
				hold_request = 1'b1;
			req = ($urandom_range(0, 99) < set_pct) ? REQ_SET_TARGET : REQ_ADVANCE;
			pick = $urandom_range(0, 99);
			if (pick < 15)
				tv = sb.tgt;
			else if (pick < 25)
				tv = sb.cur;
			else if (pick < 30)
				tv = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF;
			else
				tv = 16'($urandom_range(0, 65535));
			pick = $urandom_range(0, 99);
			if (long_glide)
				ticks = (pick < 90) ? 8'hFF : 8'($urandom_range(0, 255));
			else if (pick < 10)
				ticks = 8'h00;
			else if (pick < 20)
				ticks = 8'hFF;
			else if (pick < 60)
				ticks = 8'($urandom_range(1, 20));
			else
				ticks = 8'($urandom_range(0, 255));
			send_item(req, tv, ticks);
		end
	endtask

	// Main sequence: reset, directed cases, random phases, final check.
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		hold_request = 1'b0;
		sb.clear_state();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Zero speed: a new target is reached on the first advance.
		send_item(REQ_SET_TARGET, 16'hFFFF, 8'hA5);
		send_item(REQ_ADVANCE, 16'h5A5A, 8'h00);
		// Settled advance, then a target equal to the stored one.
		send_item(REQ_ADVANCE, 16'h0000, 8'hFF);
		send_item(REQ_SET_TARGET, 16'hFFFF, 8'h00);

		// Shortest fixed glide; indexes past the last register are ignored.
		write_reg(REG_GLIDE_SPEED, 16'd1);
		write_reg(REG_PROP_MODE, 16'hFFFE);
		write_reg(8'd2, 16'hFFFF);
		write_reg(8'hFF, 16'h1234);
		send_item(REQ_SET_TARGET, 16'h0000, 8'h00);
		send_item(REQ_ADVANCE, 16'h0000, 8'h01);

		// Longest fixed glide with intermediate steps and a retarget midway.
		write_reg(REG_GLIDE_SPEED, 16'hFFFF);
		send_item(REQ_SET_TARGET, 16'd40000, 8'h00);
		send_item(REQ_ADVANCE, 16'h0000, 8'hFF);
		send_item(REQ_ADVANCE, 16'h0000, 8'h00);
		send_item(REQ_ADVANCE, 16'h0000, 8'h80);
		send_item(REQ_SET_TARGET, sb.cur, 8'h00);
		send_item(REQ_SET_TARGET, 16'd1, 8'h00);
		send_item(REQ_ADVANCE, 16'h0000, 8'hFF);

		// Switching to proportional mode recomputes the length mid-glide.
		write_reg(REG_PROP_MODE, 16'h0001);
		send_item(REQ_ADVANCE, 16'h0000, 8'hFF);

		// A zero divisor from a zero target, then from a zero output.
		write_reg(REG_GLIDE_SPEED, 16'd300);
		send_item(REQ_SET_TARGET, 16'h0000, 8'h00);
		send_item(REQ_ADVANCE, 16'h0000, 8'd17);
		send_item(REQ_SET_TARGET, 16'd5000, 8'h00);
		send_item(REQ_ADVANCE, 16'h0000, 8'd3);

		// Lengths that saturate, upward and downward.
		write_reg(REG_GLIDE_SPEED, 16'hFFFF);
		send_item(REQ_SET_TARGET, 16'hFFFF, 8'h00);
		send_item(REQ_ADVANCE, 16'h0000, 8'hFF);
		send_item(REQ_ADVANCE, 16'h0000, 8'hFF);
		send_item(REQ_SET_TARGET, 16'd1, 8'h00);
		send_item(REQ_ADVANCE, 16'h0000, 8'd200);

		// Random phases over several settings.
		setup_phase(16'd0, 1'b0);
		random_phase(120, 40, 1'b0, -1);
		setup_phase(16'd1, 1'b0);
		random_phase(150, 30, 1'b0, -1);
		// Long fixed glides let the elapsed count saturate.
		setup_phase(16'hFFFF, 1'b0);
		random_phase(300, 2, 1'b0 | 1'b1, -1);
		// The receiver holds off here while items keep coming.
		setup_phase(16'($urandom_range(2, 2000)), 1'b0);
		random_phase(200, 25, 1'b0, 60);
		drain();
		setup_phase(16'($urandom_range(1, 65535)), 1'b1);
		random_phase(200, 25, 1'b0, -1);
		setup_phase(16'hFFFF, 1'b1);
		random_phase(150, 25, 1'b0, -1);
		setup_phase(16'($urandom_range(1, 50)), 1'b1);
		random_phase(200, 25, 1'b0, -1);

		// Closing part without idling on either side.
		calm = 1'b1;
		setup_phase(16'd0, 1'b1);
		random_phase(60, 40, 1'b0, -1);
		setup_phase(16'($urandom_range(1, 20)), 1'b0);
		random_phase(100, 30, 1'b0, -1);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.mismatch_count == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ----- files.f -----
design/pglide_pkg.sv
design/pglide_seq.sv
design/pglide_dp.sv
design/portamento_glide.sv
bench/tb_top.sv
